[hw/rtl/mspid_pkg.sv]
`timescale 1ns / 1ps

package mspid_pkg;

   // field widths
   localparam int GainW  = 16;
   localparam int RpmW   = 14;
   localparam int ErrW   = RpmW + 1;      // target - speed, signed
   localparam int SumW   = 16;            // saturating error accumulator
   localparam int DiffW  = 16;            // err - last_err, signed
   localparam int LevelW = 8;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = GainW;

   // product and sum widths (gains enter as positive signed values)
   localparam int PTermW = GainW + 1 + ErrW;
   localparam int ITermW = GainW + 1 + SumW;
   localparam int DTermW = GainW + 1 + DiffW;
   localparam int RawW   = ITermW + 2;

   // drive scaling: raw / 8000, clamped to 0..255
   localparam int Divisor  = 8000;
   localparam int DriveMax = 255;
   localparam logic signed [RawW-1:0] RawLimit = RawW'(DriveMax * Divisor);

   // raw / 8000 == (raw >> 6) / 125, the latter by reciprocal multiply
   localparam int PreShift   = 6;
   localparam int QuotDiv    = Divisor / (1 << PreShift);
   localparam int QuotInW    = 15;        // (255*8000) >> 6 fits in 15 bits
   localparam int RecipShift = 22;
   localparam int RecipW     = 16;
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((1 << RecipShift) + QuotDiv - 1) / QuotDiv);
   localparam int QuotProdW  = QuotInW + RecipW;

   // register reset values
   localparam logic [GainW-1:0] PropGainRst  = GainW'(200);
   localparam logic [GainW-1:0] IntegGainRst = GainW'(5);
   localparam logic [GainW-1:0] DerivGainRst = GainW'(500);
   localparam logic [RpmW-1:0]  TargetRpmRst = RpmW'(50);

   typedef enum logic [CsrIdxW-1:0] {
      REG_PROP_GAIN  = 2'd0,
      REG_INTEG_GAIN = 2'd1,
      REG_DERIV_GAIN = 2'd2,
      REG_TARGET_RPM = 2'd3
   } csr_idx_type;

   // operands of one sample, taken before the state update
   typedef struct packed {
      logic signed [ErrW-1:0]  err;
      logic signed [SumW-1:0]  sum;
      logic signed [DiffW-1:0] diff;
   } operand_type;

endpackage

[hw/rtl/mspid_error_state.sv]
`timescale 1ns / 1ps

module mspid_error_state (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic                         clear_last,
   input  logic [mspid_pkg::RpmW-1:0]   target,
   input  logic [mspid_pkg::RpmW-1:0]   speed,
   output mspid_pkg::operand_type       ops
);
   import mspid_pkg::*;

   logic signed [ErrW-1:0]  err;
   logic signed [DiffW-1:0] diff;
   logic signed [SumW:0]    sum_wide;
   logic signed [SumW-1:0]  sum_sat;

   logic signed [ErrW-1:0]  last_error_ff, last_error_in;
   logic signed [SumW-1:0]  error_sum_ff, error_sum_in;

   assign err      = signed'({1'b0, target}) - signed'({1'b0, speed});
   assign diff     = DiffW'(err) - DiffW'(last_error_ff);
   assign sum_wide = (SumW+1)'(error_sum_ff) + (SumW+1)'(err);

   // saturate when the two top bits disagree
   always_comb begin
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end
   end

   always_comb begin
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      if (take) begin
         last_error_in = err;
         error_sum_in  = sum_sat;
      end
      if (clear_last) begin
         last_error_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   assign ops.err  = err;
   assign ops.sum  = error_sum_ff;
   assign ops.diff = diff;

endmodule

[hw/rtl/motor_speed_pid_controller_core.sv]
`timescale 1ns / 1ps

// Motor speed PID controller.
// req_ channel: one measured speed (rpm) per transfer. rsp_ channel: one PWM
// drive level per sample, with a flag set when the raw PID sum was clipped
// to 0 or 255. csr_ port: write-only gains and target speed; writing the
// target also clears the stored previous error.
// The error state (previous error, saturating error sum) updates on the same
// edge that the sample transfers, so a sample may follow in every cycle.
// Pipeline: the req transfer loads the operand register, then the product,
// sum/clamp and output registers follow before rsp_tvalid rises.
// Throughput: one sample per cycle while rsp_tready does not hold the
// pipeline; the three gain multiplies share one stage and the reciprocal
// multiply that replaces the divide by 8000 sits in the output stage.
// Reset: gains return to 200/5/500 hundredths, target to 50 rpm, error state
// and all stage valid bits clear.
// Stall: when rsp_tready is low, the pipeline keeps filling its empty stages
// and req_tready drops only once all four stages hold a sample.
module motor_speed_pid_controller_core (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [13:0] measured_rpm, [15:14] zero
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mspid_pkg::LevelW-1:0]  rsp_tdata,   // [7:0] drive_level
   output logic                          rsp_tuser,   // [0] clamped
   // register writes
   input  logic                          csr_wen,
   input  logic [mspid_pkg::CsrIdxW-1:0] csr_addr,
   input  logic [mspid_pkg::CsrDataW-1:0] csr_wdata
);
   import mspid_pkg::*;

   // config registers
   logic [GainW-1:0] prop_gain_ff,  prop_gain_in;
   logic [GainW-1:0] integ_gain_ff, integ_gain_in;
   logic [GainW-1:0] deriv_gain_ff, deriv_gain_in;
   logic [RpmW-1:0]  target_rpm_ff, target_rpm_in;
   logic             target_wr;

   // pipeline load enables, last stage first
   logic ld_out, ld3, ld2, ld1;
   logic req_xfer;

   // stage 1: operands
   logic        s1_v_ff, s1_v_in;
   operand_type ops;
   operand_type s1_ops_ff;

   // stage 2: products
   logic                     s2_v_ff, s2_v_in;
   logic signed [PTermW-1:0] p_term_ff, p_term_in;
   logic signed [ITermW-1:0] i_term_ff, i_term_in;
   logic signed [DTermW-1:0] d_term_ff, d_term_in;

   // stage 3: raw sum, clamp decision
   logic                      s3_v_ff, s3_v_in;
   logic signed [RawW-1:0]    raw;
   logic                      raw_neg, raw_over;
   logic                      s3_neg_ff, s3_over_ff;
   logic [QuotInW-1:0]        s3_quo_ff;

   // output stage
   logic                   rsp_v_ff, rsp_v_in;
   logic [QuotProdW-1:0]   quo_prod;
   logic [LevelW-1:0]      level_in, level_ff;
   logic                   clamp_in, clamp_ff;

   // ---------------- configuration ----------------
   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      target_rpm_in = target_rpm_ff;
      target_wr     = 1'b0;
      if (csr_wen) begin
         unique case (csr_idx_type'(csr_addr))
            REG_PROP_GAIN:  prop_gain_in  = csr_wdata;
            REG_INTEG_GAIN: integ_gain_in = csr_wdata;
            REG_DERIV_GAIN: deriv_gain_in = csr_wdata;
            REG_TARGET_RPM: begin
               target_rpm_in = csr_wdata[RpmW-1:0];
               target_wr     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PropGainRst;
         integ_gain_ff <= IntegGainRst;
         deriv_gain_ff <= DerivGainRst;
         target_rpm_ff <= TargetRpmRst;
      end else begin
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         target_rpm_ff <= target_rpm_in;
      end
   end

   // ---------------- flow control ----------------
   // a stage loads when it is empty or its content moves on this edge
   assign ld_out     = !rsp_v_ff || rsp_tready;
   assign ld3        = !s3_v_ff || ld_out;
   assign ld2        = !s2_v_ff || ld3;
   assign ld1        = !s1_v_ff || ld2;
   assign req_tready = ld1;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_v_in  = ld1    ? req_xfer : s1_v_ff;
   assign s2_v_in  = ld2    ? s1_v_ff  : s2_v_ff;
   assign s3_v_in  = ld3    ? s2_v_ff  : s3_v_ff;
   assign rsp_v_in = ld_out ? s3_v_ff  : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // ---------------- stage 1: error state ----------------
   mspid_error_state u_state (
      .clock      (clock),
      .reset      (reset),
      .take       (req_xfer),
      .clear_last (target_wr),
      .target     (target_rpm_ff),
      .speed      (req_tdata[RpmW-1:0]),
      .ops        (ops)
   );

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_ops_ff <= ops;
      end
   end

   // ---------------- stage 2: gain products ----------------
   assign p_term_in = signed'({1'b0, prop_gain_ff})  * s1_ops_ff.err;
   assign i_term_in = signed'({1'b0, integ_gain_ff}) * s1_ops_ff.sum;
   assign d_term_in = signed'({1'b0, deriv_gain_ff}) * s1_ops_ff.diff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         p_term_ff <= p_term_in;
         i_term_ff <= i_term_in;
         d_term_ff <= d_term_in;
      end
   end

   // ---------------- stage 3: sum and range check ----------------
   assign raw      = RawW'(p_term_ff) + RawW'(i_term_ff) + RawW'(d_term_ff);
   assign raw_neg  = raw[RawW-1];
   assign raw_over = !raw_neg && (raw > RawLimit);

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_neg_ff  <= raw_neg;
         s3_over_ff <= raw_over;
         s3_quo_ff  <= raw[PreShift +: QuotInW];
      end
   end

   // ---------------- output: divide by 8000 and clamp ----------------
   // exact for every in-range value: (raw >> 6) * ceil(2^22 / 125) >> 22
   assign quo_prod = QuotProdW'(s3_quo_ff) * QuotProdW'(Recip);

   always_comb begin
      priority if (s3_neg_ff) begin
         level_in = '0;
      end else if (s3_over_ff) begin
         level_in = LevelW'(DriveMax);
      end else begin
         level_in = quo_prod[RecipShift +: LevelW];
      end
   end
   assign clamp_in = s3_neg_ff || s3_over_ff;

   always_ff @(posedge clock) begin
      if (ld_out) begin
         level_ff <= level_in;
         clamp_ff <= clamp_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = level_ff;
   assign rsp_tuser  = clamp_ff;

   // ---------------- assertions ----------------
   // a clipped result sits at one of the rails
   a_clamp_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == '0 || rsp_tdata == LevelW'(DriveMax)))
      else $error("clamped result not at a rail");

   // input back-pressure only when every stage holds a sample
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_v_ff && s2_v_ff && s3_v_ff && rsp_v_ff && !rsp_tready))
      else $error("input stalled with an empty stage");

   // an accepted sample always lands in stage 1
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_v_ff)
      else $error("accepted sample lost");

   // negative and over-range cannot both hold
   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> !(s3_neg_ff && s3_over_ff))
      else $error("raw sum flagged both negative and over range");

endmodule

[test/tb_motor_speed_pid_controller_core.sv]
`timescale 1ns / 1ps

module tb_motor_speed_pid_controller_core;
   import mspid_pkg::*;

   localparam int PipeDepth   = 3;       // sets the drain wait in settle()
   localparam int CycleLimit  = 200000;  // slowest correct run is far below this
   localparam int RandPhases  = 8;
   localparam int PhaseItems  = 50;
   localparam int PlanRows    = 39;
   localparam int HoldCycles  = 300;     // long receiver hold-off
   localparam int HoldAfter   = 40;      // results seen before the hold-off starts

   // ---------------------------------------------------------------------
   // clock, reset, DUT ports
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // [13:0] measured_rpm, [15:14] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [LevelW-1:0]     rsp_tdata;         // [7:0] drive_level
   logic                  rsp_tuser;         // [0] clamped
   logic                  csr_wen    = 1'b0;
   logic [CsrIdxW-1:0]    csr_addr   = '0;
   logic [CsrDataW-1:0]   csr_wdata  = '0;

   motor_speed_pid_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // controller model: gains, setpoint and error state as the block holds them
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [LevelW-1:0] level;
      logic              clamped;
   } drive_item_type;

   logic [GainW-1:0]        kp_q     = PropGainRst;
   logic [GainW-1:0]        ki_q     = IntegGainRst;
   logic [GainW-1:0]        kd_q     = DerivGainRst;
   logic [RpmW-1:0]         set_rpm  = TargetRpmRst;
   logic signed [DiffW-1:0] prev_err = '0;
   logic signed [SumW-1:0]  err_acc  = '0;

   drive_item_type drive_expected [$];   // drive levels still owed by the block
   int             mismatches   = 0;
   int             results_seen = 0;

   // one control step: drive from the error terms, then error state update
   function automatic drive_item_type predict_drive(input logic [RpmW-1:0] rpm);
      drive_item_type r;
      int             err;
      int             diff;
      int             acc;
      longint         raw;
      err  = int'(set_rpm) - int'(rpm);
      diff = err - int'(prev_err);
      // integral term uses the sum from before this sample
      raw  = longint'(kp_q) * longint'(err)
           + longint'(ki_q) * longint'(err_acc)
           + longint'(kd_q) * longint'(diff);
      if (raw < 0) begin
         r.level   = '0;
         r.clamped = 1'b1;
      end else if (raw > longint'(DriveMax) * longint'(Divisor)) begin
         r.level   = LevelW'(DriveMax);
         r.clamped = 1'b1;
      end else begin
         // exactly 255*8000 lands here: full drive, no clamp flag
         r.level   = LevelW'(raw / Divisor);
         r.clamped = 1'b0;
      end
      prev_err = DiffW'(err);
      acc = int'(err_acc) + err;
      if (acc > 32767)  acc = 32767;
      if (acc < -32768) acc = -32768;
      err_acc = SumW'(acc);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // directed plan: register writes and speed samples, walked in order
   // ---------------------------------------------------------------------
   typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_idx_type       reg_idx;
      logic [15:0]       wval;
      logic [RpmW-1:0]   rpm;
      logic              known;     // expected drive typed in the row
      logic [LevelW-1:0] level;
      logic              clamped;
   } plan_row_type;

   plan_row_type directed_plan [PlanRows];

   function automatic plan_row_type row_sample(input logic [RpmW-1:0] rpm);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.rpm  = rpm;
      return r;
   endfunction

   function automatic plan_row_type row_check(input logic [RpmW-1:0] rpm,
                                              input logic [LevelW-1:0] level,
                                              input logic clamped);
      plan_row_type r;
      r = row_sample(rpm);
      r.known   = 1'b1;
      r.level   = level;
      r.clamped = clamped;
      return r;
   endfunction

   function automatic plan_row_type row_write(input csr_idx_type idx,
                                              input logic [15:0] val);
      plan_row_type r;
      r = '0;
      r.kind    = ROW_WRITE;
      r.reg_idx = idx;
      r.wval    = val;
      return r;
   endfunction

   // random gain: extremes, usual tuning range, or anything
   function automatic logic [GainW-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return GainW'($urandom_range(0, 600));
         4:       return GainW'($urandom_range(0, 4000));
         default: return GainW'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // sender side tasks
   // ---------------------------------------------------------------------
   // Offer one speed sample and hold it until the transfer; valid stays high
   // afterwards so a following sample goes back to back.
   task automatic send_sample(input logic [RpmW-1:0] rpm, input logic known,
                              input logic [LevelW-1:0] level, input logic clamped);
      drive_item_type predicted;
      if (csr_wen) csr_wen <= 1'b0;
      req_tdata  <= {2'b00, rpm};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_drive(rpm);
      if (known) drive_expected.push_back('{level, clamped});
      else       drive_expected.push_back(predicted);
   endtask

   // Stop offering and let the pipeline drain completely.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   // Register write; csr_wen stays high for a following write and is
   // dropped by the next sample.
   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_PROP_GAIN:  kp_q = val;
         REG_INTEG_GAIN: ki_q = val;
         REG_DERIV_GAIN: kd_q = val;
         REG_TARGET_RPM: begin
            // new setpoint drops the previous error, sum is kept
            set_rpm  = val[RpmW-1:0];
            prev_err = '0;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_drive
      drive_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (drive_expected.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected drive transfer: level %0d clamped %0b",
                        rsp_tdata, rsp_tuser);
         end else begin
            want = drive_expected.pop_front();
            if (rsp_tdata !== want.level || rsp_tuser !== want.clamped) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display({"drive mismatch: expected level %0d clamped %0b, ",
                            "got level %0d clamped %0b"},
                           want.level, want.clamped, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern changes per stretch, plus one long hold-off
   // while the sender keeps offering so the pipeline fills and req_tready drops
   // ---------------------------------------------------------------------
   int   ready_mode = 0;
   int   stretch    = 0;
   int   long_hold  = 0;
   logic hold_done  = 1'b0;

   always @(posedge clock) begin
      if (long_hold > 0) begin
         long_hold  <= long_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
         hold_done  <= 1'b1;
         long_hold  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (stretch == 0) begin
            ready_mode <= $urandom_range(0, 3);
            stretch    <= $urandom_range(8, 64);
         end else begin
            stretch <= stretch - 1;
         end
         case (ready_mode)
            0:       rsp_tready <= 1'b1;                          // no stalls
            1:       rsp_tready <= 1'($urandom_range(0, 1));     // heavy stalls
            2:       rsp_tready <= (stretch % 3 == 0);            // periodic
            default: rsp_tready <= ($urandom_range(0, 9) != 0);  // light stalls
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------------
   int cycles = 0;

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int              burst_left;
      int              gap;
      int              near;
      logic            gapless;
      logic [RpmW-1:0] rpm;
      logic [15:0]     tgt;

      directed_plan = '{
         // reset settings: zero error, then both signs of a huge error
         row_check(14'd50, 8'd0, 1'b0),
         row_check(14'd16383, 8'd0, 1'b1),
         row_sample(14'd0),
         row_sample(14'd0),
         row_sample(14'd8191),
         // pure P with 8000 hundredths: drive equals the error
         row_write(REG_PROP_GAIN, 16'd8000),
         row_write(REG_INTEG_GAIN, 16'd0),
         row_write(REG_DERIV_GAIN, 16'd0),
         row_write(REG_TARGET_RPM, 16'd255),
         row_check(14'd0, 8'd255, 1'b0),       // exactly 255*8000, not clamped
         row_check(14'd1, 8'd254, 1'b0),
         row_check(14'd255, 8'd0, 1'b0),
         row_check(14'd16383, 8'd0, 1'b1),     // negative raw drive
         row_write(REG_TARGET_RPM, 16'd256),
         row_check(14'd0, 8'd255, 1'b1),       // just above full scale
         row_write(REG_PROP_GAIN, 16'd0),
         row_check(14'd0, 8'd0, 1'b0),
         // all gains maxed, setpoint past its nominal range; sum saturates high
         row_write(REG_PROP_GAIN, 16'hFFFF),
         row_write(REG_INTEG_GAIN, 16'hFFFF),
         row_write(REG_DERIV_GAIN, 16'hFFFF),
         row_write(REG_TARGET_RPM, 16'd16383),
         row_sample(14'd0),
         row_sample(14'd0),
         row_sample(14'd0),
         row_sample(14'd0),
         row_sample(14'h1555),
         // setpoint zero, max speed: sum saturates low
         row_write(REG_TARGET_RPM, 16'd0),
         row_sample(14'd16383),
         row_sample(14'd16383),
         row_sample(14'd16383),
         row_sample(14'd16383),
         row_sample(14'h2AAA),
         // D only; setpoint write must clear the previous error
         row_write(REG_PROP_GAIN, 16'd0),
         row_write(REG_INTEG_GAIN, 16'd0),
         row_write(REG_DERIV_GAIN, 16'hFFFF),
         row_write(REG_TARGET_RPM, 16'd10000),
         row_check(14'd10000, 8'd0, 1'b0),
         row_check(14'd9999, 8'd8, 1'b0),
         row_check(14'd10001, 8'd0, 1'b1)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            if (!csr_wen) settle();
            write_reg(directed_plan[i].reg_idx, directed_plan[i].wval);
         end else begin
            send_sample(directed_plan[i].rpm, directed_plan[i].known,
                        directed_plan[i].level, directed_plan[i].clamped);
         end
      end

      // random phases: new settings on an idle block, then mostly samples
      // around the setpoint as a running loop would see them
      for (int phase = 0; phase < RandPhases; phase++) begin
         settle();
         write_reg(REG_PROP_GAIN, pick_gain());
         write_reg(REG_INTEG_GAIN, pick_gain());
         write_reg(REG_DERIV_GAIN, pick_gain());
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       tgt = 16'd0;
               1:       tgt = 16'd10000;
               2:       tgt = 16'($urandom_range(10001, 16383));
               default: tgt = 16'($urandom_range(0, 10000));
            endcase
            // upper data bits are don't-care for the 14-bit setpoint
            tgt[15:14] = 2'($urandom_range(0, 3));
            write_reg(REG_TARGET_RPM, tgt);
         end
         gapless    = (phase == 2) || ($urandom_range(0, 4) == 0);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < PhaseItems; n++) begin
            case ($urandom_range(0, 19))
               0:       rpm = '0;
               1:       rpm = '1;
               2, 3, 4: rpm = RpmW'($urandom_range(0, 16383));
               default: begin
                  near = int'(set_rpm) + int'($urandom_range(0, 80)) - 40;
                  if (near < 0)     near = 0;
                  if (near > 16383) near = 16383;
                  rpm = RpmW'(near);
               end
            endcase
            send_sample(rpm, 1'b0, '0, 1'b0);
            if (!gapless) begin
               burst_left--;
               if (burst_left == 0) begin
                  gap = $urandom_range(1, 8);
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
                  burst_left = $urandom_range(1, 24);
               end
            end
         end
      end

      settle();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
